// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of the merge block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kwm_pkg.sv =====
// Package of the k-way merge block: shared constants, codes and types.
// Used by kwm_cell, k_way_merge_min_heap_top and the testbench; depends on nothing.
package kwm_pkg;

  // Default sizing of the heap and of the element store.
  localparam int MAX_LISTS_DEF       = 8;
  localparam int MAX_LIST_LENGTH_DEF = 32;

  // Width of one element value.
  localparam int VALUE_W = 32;

  // Configuration registers.
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int LISTS_W   = 4;
  localparam int LENGTH_W  = 6;
  localparam logic [LISTS_W-1:0]  LISTS_RST  = 4'd8;
  localparam logic [LENGTH_W-1:0] LENGTH_RST = 6'd32;

  typedef enum logic [0:0] {
    REG_LISTS  = 1'b0,
    REG_LENGTH = 1'b1
  } reg_e;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_POP   = 2'd2
  } op_e;

  // Which entry of a node and its children ranks lowest.
  typedef enum logic [1:0] {
    PICK_NONE  = 2'd0,
    PICK_LEFT  = 2'd1,
    PICK_RIGHT = 2'd2
  } pick_e;

  // Per-cell update command.
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
    logic take_parent;
  } cell_cmd_t;

endpackage

// ===== sv/kwm_cell.sv =====
// One heap cell of the merge block: holds one heap entry, ranks it against
// its two children and swaps with its parent or a child. Uses kwm_pkg.
module kwm_cell
  import kwm_pkg::*;
#(
  parameter int  MAX_LISTS       = MAX_LISTS_DEF,
  parameter int  MAX_LIST_LENGTH = MAX_LIST_LENGTH_DEF,
  parameter int  IDX             = 0,
  localparam int LW              = $clog2(MAX_LISTS),
  localparam int NW              = $clog2(MAX_LIST_LENGTH + 1),
  localparam int KW              = $clog2(MAX_LISTS + 1),
  localparam int EW              = VALUE_W + LW + NW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_cmd_t     cmd_i,
  input  logic [KW-1:0] k_i,
  input  logic [EW-1:0] load_entry_i,
  input  logic [EW-1:0] parent_entry_i,
  input  logic [EW-1:0] left_entry_i,
  input  logic [EW-1:0] right_entry_i,
  output logic [EW-1:0] entry_o,
  output pick_e         pick_o
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LW-1:0]             list;
    logic [NW-1:0]             next;
    logic                      spent;
  } entry_t;

  entry_t entry_q, entry_d;
  entry_t left_e, right_e, least_e;
  logic   left_ok, right_ok, left_wins, right_wins;

  // Rank this entry against its children; a spent entry ranks above all values.
  always_comb begin
    left_e   = entry_t'(left_entry_i);
    right_e  = entry_t'(right_entry_i);
    left_ok  = 32'(k_i) > 32'(2 * IDX + 1);
    right_ok = 32'(k_i) > 32'(2 * IDX + 2);
    left_wins = left_ok && !left_e.spent &&
                (entry_q.spent || (left_e.value < entry_q.value));
    least_e   = left_wins ? left_e : entry_q;
    right_wins = right_ok && !right_e.spent &&
                 (least_e.spent || (right_e.value < least_e.value));
    if (right_wins) begin
      pick_o = PICK_RIGHT;
    end else if (left_wins) begin
      pick_o = PICK_LEFT;
    end else begin
      pick_o = PICK_NONE;
    end
  end

  // Select the new content: a direct load or one side of a swap.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.load) begin
      entry_d = entry_t'(load_entry_i);
    end else if (cmd_i.take_left) begin
      entry_d = entry_t'(left_entry_i);
    end else if (cmd_i.take_right) begin
      entry_d = entry_t'(right_entry_i);
    end else if (cmd_i.take_parent) begin
      entry_d = entry_t'(parent_entry_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== sv/k_way_merge_min_heap_top.sv =====
// Top level of the k-way merge block: element store, heap of kwm_cell, control.
// Depends on kwm_pkg, kwm_cell and assert_macros.svh.
// Load writes one element to the store. Start reads each list's head into the heap, then sifts.
// Pop: result registered at the accepting edge; the block then stays busy for a store read
// and a replace (or marking the root spent), then sifts down one heap level per cycle.
// Reset is asynchronous, active low; it clears the heap and control, not the store.
`include "assert_macros.svh"

module k_way_merge_min_heap_top
  import kwm_pkg::*;
#(
  parameter int MAX_LISTS       = MAX_LISTS_DEF,
  parameter int MAX_LIST_LENGTH = MAX_LIST_LENGTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input items
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic [2:0]                list_number_i,
  input  logic [4:0]                position_i,
  input  logic signed [VALUE_W-1:0] element_value_i,
  // Result items
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] merged_value_o,
  output logic                      last_flag_o,
  output logic                      status_o,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  localparam int LW    = $clog2(MAX_LISTS);
  localparam int NW    = $clog2(MAX_LIST_LENGTH + 1);
  localparam int KW    = $clog2(MAX_LISTS + 1);
  localparam int DEPTH = MAX_LISTS * MAX_LIST_LENGTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = VALUE_W + LW + NW + 1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LW-1:0]             list;
    logic [NW-1:0]             next;
    logic                      spent;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_REPLACE,
    ST_SIFT
  } state_e;

  // Control registers.
  state_e              state_q, state_d;
  logic [LW-1:0]       node_q, node_d;
  logic [LW-1:0]       heap_top_q, heap_top_d;
  logic                building_q, building_d;
  logic [KW-1:0]       fill_cnt_q, fill_cnt_d;
  logic                merging_q, merging_d;
  logic [CW-1:0]       emitted_q, emitted_d;
  logic [LISTS_W-1:0]  cfg_lists_q, cfg_lists_d;
  logic [LENGTH_W-1:0] cfg_length_q, cfg_length_d;
  logic                out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic                out_last_q, out_last_d;
  logic                out_status_q, out_status_d;

  // Element store.
  logic [VALUE_W-1:0]  store_mem [DEPTH];
  logic [VALUE_W-1:0]  rdata_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;

  // Heap cells.
  logic [EW-1:0]       cell_entry [MAX_LISTS];
  pick_e               cell_pick [MAX_LISTS];
  entry_t              root_e, load_entry;
  pick_e               sel_pick;
  logic                step_en, fill_we, root_we;
  logic [LW-1:0]       fill_idx;

  // Misc.
  logic [KW-1:0]       k_eff;
  logic [NW-1:0]       n_eff;
  logic [CW-1:0]       total, emitted_inc;
  logic                in_acc, pop_acc, out_full, pop_empty, apb_wr;
  logic [LW-1:0]       child_idx;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  // Register read-back.
  always_comb begin
    unique case (reg_e'(paddr[APB_AW-1]))
      REG_LISTS:  prdata = APB_DW'(cfg_lists_q);
      REG_LENGTH: prdata = APB_DW'(cfg_length_q);
      default:    prdata = '0;
    endcase
  end

  // Effective k and n, saturated to the sizes the hardware holds.
  always_comb begin
    if (cfg_lists_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(cfg_lists_q) > MAX_LISTS) begin
      k_eff = KW'(MAX_LISTS);
    end else begin
      k_eff = KW'(cfg_lists_q);
    end
    if (cfg_length_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(cfg_length_q) > MAX_LIST_LENGTH) begin
      n_eff = NW'(MAX_LIST_LENGTH);
    end else begin
      n_eff = NW'(cfg_length_q);
    end
    total       = CW'(n_eff) * CW'(k_eff);
    emitted_inc = emitted_q + CW'(1);
  end

  // Handshake.
  assign out_full    = out_valid_q && out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || ((operation_i == OP_POP) && out_full);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign pop_acc     = in_acc && (operation_i == OP_POP);

  assign root_e    = entry_t'(cell_entry[0]);
  assign sel_pick  = cell_pick[node_q];
  assign pop_empty = !merging_q || (emitted_q >= total) || root_e.spent;
  assign fill_idx  = LW'(fill_cnt_q - KW'(1));
  assign child_idx = (sel_pick == PICK_RIGHT) ? LW'(32'(node_q) * 2 + 2)
                                              : LW'(32'(node_q) * 2 + 1);

  // Sequencer: next state, store access and heap commands.
  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    heap_top_d   = heap_top_q;
    building_d   = building_q;
    fill_cnt_d   = fill_cnt_q;
    merging_d    = merging_q;
    emitted_d    = emitted_q;
    cfg_lists_d  = cfg_lists_q;
    cfg_length_d = cfg_length_q;
    out_valid_d  = out_full;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = AW'(32'(list_number_i) * MAX_LIST_LENGTH + 32'(position_i));
    mem_raddr    = '0;
    step_en      = 1'b0;
    fill_we      = 1'b0;
    root_we      = 1'b0;
    load_entry   = root_e;

    if (apb_wr) begin
      unique case (reg_e'(paddr[APB_AW-1]))
        REG_LISTS:  cfg_lists_d  = pwdata[LISTS_W-1:0];
        REG_LENGTH: cfg_length_d = pwdata[LENGTH_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_e'(operation_i))
            OP_LOAD: begin
              mem_we = (32'(list_number_i) < MAX_LISTS) &&
                       (32'(position_i) < MAX_LIST_LENGTH);
            end
            OP_START: begin
              // List 0, position 0 sits at store address zero.
              mem_re     = 1'b1;
              mem_raddr  = '0;
              fill_cnt_d = KW'(1);
              emitted_d  = '0;
              merging_d  = 1'b1;
              state_d    = ST_FILL;
            end
            OP_POP: begin
              out_valid_d = 1'b1;
              if (pop_empty) begin
                out_value_d  = '0;
                out_last_d   = 1'b0;
                out_status_d = 1'b1;
              end else begin
                out_value_d  = root_e.value;
                out_last_d   = (emitted_inc == total);
                out_status_d = 1'b0;
                emitted_d    = emitted_inc;
                node_d       = '0;
                building_d   = 1'b0;
                if (root_e.next < n_eff) begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(32'(root_e.list) * MAX_LIST_LENGTH + 32'(root_e.next));
                  state_d   = ST_REPLACE;
                end else begin
                  // List exhausted: mark the root spent and sift it down.
                  root_we          = 1'b1;
                  load_entry.spent = 1'b1;
                  state_d          = ST_SIFT;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_FILL: begin
        // Write the head element of list fill_cnt-1, fetch the next head.
        fill_we          = 1'b1;
        load_entry.value = rdata_q;
        load_entry.list  = fill_idx;
        load_entry.next  = NW'(1);
        load_entry.spent = 1'b0;
        if (fill_cnt_q < k_eff) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(32'(fill_cnt_q) * MAX_LIST_LENGTH);
          fill_cnt_d = fill_cnt_q + KW'(1);
        end else begin
          heap_top_d = LW'((32'(k_eff) - 32'd1) >> 1);
          node_d     = LW'((32'(k_eff) - 32'd1) >> 1);
          building_d = 1'b1;
          state_d    = ST_SIFT;
        end
      end

      ST_REPLACE: begin
        // The next element of the root's list replaces the root.
        root_we          = 1'b1;
        load_entry.value = rdata_q;
        load_entry.next  = root_e.next + NW'(1);
        load_entry.spent = 1'b0;
        state_d          = ST_SIFT;
      end

      ST_SIFT: begin
        if (sel_pick != PICK_NONE) begin
          step_en = 1'b1;
          node_d  = child_idx;
        end else if (building_q && (heap_top_q != '0)) begin
          heap_top_d = heap_top_q - LW'(1);
          node_d     = heap_top_q - LW'(1);
        end else begin
          building_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_q       <= '0;
      heap_top_q   <= '0;
      building_q   <= 1'b0;
      fill_cnt_q   <= '0;
      merging_q    <= 1'b0;
      emitted_q    <= '0;
      cfg_lists_q  <= LISTS_RST;
      cfg_length_q <= LENGTH_RST;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_q       <= node_d;
      heap_top_q   <= heap_top_d;
      building_q   <= building_d;
      fill_cnt_q   <= fill_cnt_d;
      merging_q    <= merging_d;
      emitted_q    <= emitted_d;
      cfg_lists_q  <= cfg_lists_d;
      cfg_length_q <= cfg_length_d;
      out_valid_q  <= out_valid_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_value_q;
  assign last_flag_o    = out_last_q;
  assign status_o       = out_status_q;

  // Element store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= element_value_i;
    end
    if (mem_re) begin
      rdata_q <= store_mem[mem_raddr];
    end
  end

  // Row of heap cells; cell i is wired to cells 2i+1, 2i+2 and (i-1)/2.
  for (genvar gi = 0; gi < MAX_LISTS; gi++) begin : g_cell
    logic [EW-1:0] left_w, right_w, parent_w;
    cell_cmd_t     cmd_w;

    if (2 * gi + 1 < MAX_LISTS) begin : g_left
      assign left_w = cell_entry[2*gi+1];
    end else begin : g_no_left
      assign left_w = '0;
    end

    if (2 * gi + 2 < MAX_LISTS) begin : g_right
      assign right_w = cell_entry[2*gi+2];
    end else begin : g_no_right
      assign right_w = '0;
    end

    if (gi > 0) begin : g_parent
      assign parent_w          = cell_entry[(gi-1)/2];
      assign cmd_w.take_parent = step_en && (node_q == LW'((gi - 1) / 2)) &&
                                 (sel_pick == (((gi % 2) == 1) ? PICK_LEFT : PICK_RIGHT));
      assign cmd_w.load        = fill_we && (fill_idx == LW'(gi));
    end else begin : g_root
      assign parent_w          = '0;
      assign cmd_w.take_parent = 1'b0;
      assign cmd_w.load        = (fill_we && (fill_idx == LW'(gi))) || root_we;
    end

    assign cmd_w.take_left  = step_en && (node_q == LW'(gi)) && (sel_pick == PICK_LEFT);
    assign cmd_w.take_right = step_en && (node_q == LW'(gi)) && (sel_pick == PICK_RIGHT);

    kwm_cell #(
      .MAX_LISTS      (MAX_LISTS),
      .MAX_LIST_LENGTH(MAX_LIST_LENGTH),
      .IDX            (gi)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd_w),
      .k_i           (k_eff),
      .load_entry_i  (load_entry),
      .parent_entry_i(parent_w),
      .left_entry_i  (left_w),
      .right_entry_i (right_w),
      .entry_o       (cell_entry[gi]),
      .pick_o        (cell_pick[gi])
    );
  end

  // Every accepted pop leaves a result in the output register.
  `ASSERT_NEXT(a_pop_gives_result, pop_acc, out_valid_o, "pop accepted without a result")
  // The sequencer leaves idle only on an accepted item.
  `ASSERT_NEXT(a_idle_holds, (state_q == ST_IDLE) && !in_acc, state_q == ST_IDLE,
               "sequencer left idle without an item")
  // Sift steps stay inside the active heap.
  `ASSERT_IMPLIES(a_sift_in_heap, state_q == ST_SIFT, 32'(node_q) < 32'(k_eff),
                  "sift node outside the heap")

endmodule

// ===== test/k_way_merge_min_heap_top_tb.sv =====
// Self-checking testbench for the k-way merge block k_way_merge_min_heap_top.
// Depends on kwm_pkg and the RTL. A scoreboard class predicts every merged value,
// and plain tasks drive the item ports and the register port.
`timescale 1ns / 1ps

module k_way_merge_min_heap_top_tb;
  import kwm_pkg::*;

  localparam int ITEM_GOAL      = 1150;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  // The fourth operation code has no meaning and must be ignored.
  localparam logic [1:0] OP_ILLEGAL = 2'd3;

  // Values for the single-element lists of the directed part.
  localparam logic [VALUE_W-1:0] CORNER [MAX_LISTS_DEF] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0005, 32'h0000_0005
  };

  // One merged result as the block should report it.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      empty;
  } merge_result_t;

  // Merge predictor and queue of merged results still to come.
  class merge_scoreboard;
    logic signed [VALUE_W-1:0] store_mem [MAX_LISTS_DEF][MAX_LIST_LENGTH_DEF];
    bit                        store_set [MAX_LISTS_DEF][MAX_LIST_LENGTH_DEF];
    logic signed [VALUE_W-1:0] node_value [MAX_LISTS_DEF];
    logic [2:0]                node_list  [MAX_LISTS_DEF];
    logic [5:0]                node_next  [MAX_LISTS_DEF];
    bit                        node_spent [MAX_LISTS_DEF];
    int unsigned               emitted;
    bit                        merging;
    logic [LISTS_W-1:0]        lists_reg;
    logic [LENGTH_W-1:0]       length_reg;
    merge_result_t             pending [$];
    int                        errors;
    int                        items;
    int                        results;
    int                        empties;

    function new();
      lists_reg  = LISTS_RST;
      length_reg = LENGTH_RST;
      foreach (node_value[i]) begin
        node_value[i] = '0;
        node_list[i]  = '0;
        node_next[i]  = '0;
      end
    endfunction

    // Register values saturate to the sizes the heap and store support.
    function int unsigned active_lists();
      if (lists_reg == 0) return 1;
      if (lists_reg > MAX_LISTS_DEF) return MAX_LISTS_DEF;
      return lists_reg;
    endfunction

    function int unsigned active_length();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_LIST_LENGTH_DEF) return MAX_LIST_LENGTH_DEF;
      return length_reg;
    endfunction

    function void set_reg(reg_e r, logic [APB_DW-1:0] d);
      if (r == REG_LISTS) lists_reg = d[LISTS_W-1:0];
      else length_reg = d[LENGTH_W-1:0];
    endfunction

    // The stimulus must never make the block read an entry it never wrote.
    function logic signed [VALUE_W-1:0] fetch(int unsigned l, int unsigned p);
      if (!store_set[l][p]) begin
        $display("%0t: stimulus made the block read unwritten list %0d position %0d",
                 $time, l, p);
        errors++;
      end
      return store_mem[l][p];
    endfunction

    // A spent list ranks above every value.
    function bit lower_than(int unsigned a, int unsigned b);
      if (node_spent[a]) return 1'b0;
      if (node_spent[b]) return 1'b1;
      return node_value[a] < node_value[b];
    endfunction

    function void exchange(int unsigned a, int unsigned b);
      logic signed [VALUE_W-1:0] v;
      logic [2:0]                l;
      logic [5:0]                x;
      bit                        s;
      v = node_value[a]; node_value[a] = node_value[b]; node_value[b] = v;
      l = node_list[a];  node_list[a]  = node_list[b];  node_list[b]  = l;
      x = node_next[a];  node_next[a]  = node_next[b];  node_next[b]  = x;
      s = node_spent[a]; node_spent[a] = node_spent[b]; node_spent[b] = s;
    endfunction

    function void sift(int unsigned node, int unsigned size);
      int unsigned left, right, least;
      while (node < size) begin
        left  = 2 * node + 1;
        right = 2 * node + 2;
        least = node;
        if (left < size && lower_than(left, node)) least = left;
        if (right < size && lower_than(right, least)) least = right;
        if (least == node) return;
        exchange(node, least);
        node = least;
      end
    endfunction

    // Apply one accepted item to the predicted state; a pop queues its result.
    function void note_input(logic [1:0] op, logic [2:0] l, logic [4:0] p,
                             logic signed [VALUE_W-1:0] v);
      int unsigned   k, n, total, i;
      int            j;
      merge_result_t r;
      k = active_lists();
      n = active_length();
      if (op != OP_ILLEGAL) items++;
      case (op)
        OP_LOAD: begin
          store_mem[l][p] = v;
          store_set[l][p] = 1'b1;
        end
        OP_START: begin
          for (i = 0; i < k; i++) begin
            node_value[i] = fetch(i, 0);
            node_list[i]  = 3'(i);
            node_next[i]  = 6'd1;
            node_spent[i] = 1'b0;
          end
          j = int'((k - 1) / 2);
          while (j >= 0) begin
            sift(j, k);
            j--;
          end
          emitted = 0;
          merging = 1'b1;
        end
        OP_POP: begin
          total = n * k;
          if (!merging || emitted >= total || node_spent[0]) begin
            r = '{value: '0, last: 1'b0, empty: 1'b1};
          end else begin
            emitted++;
            r = '{value: node_value[0], last: emitted == total, empty: 1'b0};
            if (node_next[0] < n) begin
              node_value[0] = fetch(node_list[0], node_next[0]);
              node_next[0]++;
            end else begin
              node_spent[0] = 1'b1;
            end
            sift(0, k);
          end
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic signed [VALUE_W-1:0] value, logic last, logic empty);
      merge_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: value %0d last %0b status %0b",
                 $time, value, last, empty);
        errors++;
        return;
      end
      want = pending.pop_front();
      results++;
      if (want.empty) empties++;
      if (value !== want.value) begin
        $display("%0t: merged_value expected %0d, got %0d", $time, want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_flag expected %0b, got %0b", $time, want.last, last);
        errors++;
      end
      if (empty !== want.empty) begin
        $display("%0t: status expected %0b, got %0b", $time, want.empty, empty);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [1:0]                operation_i;
  logic [2:0]                list_number_i;
  logic [4:0]                position_i;
  logic signed [VALUE_W-1:0] element_value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [VALUE_W-1:0] merged_value_o;
  logic                      last_flag_o;
  logic                      status_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  merge_scoreboard sb;
  bit              calm;
  bit              hold_req;
  int              merge_runs;
  int              idle_cycles;

  k_way_merge_min_heap_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .list_number_i  (list_number_i),
    .position_i     (position_i),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .merged_value_o (merged_value_o),
    .last_flag_o    (last_flag_o),
    .status_o       (status_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Gaps between items: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, wait until it is taken, then maybe idle for a while.
  task automatic send_item(input logic [1:0] op, input logic [2:0] l, input logic [4:0] p,
                           input logic signed [VALUE_W-1:0] v);
    int gap;
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    list_number_i   <= l;
    position_i      <= p;
    element_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, l, p, v);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering items, wait for every predicted result, then let the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write a register while the block is idle, then read it back.
  task automatic write_reg(input reg_e r, input logic [APB_DW-1:0] d);
    logic [APB_DW-1:0] want;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(r, d);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    want = (r == REG_LISTS) ? APB_DW'(d[LISTS_W-1:0]) : APB_DW'(d[LENGTH_W-1:0]);
    if (prdata !== want) begin
      $display("%0t: register %s read back expected %0d, got %0d", $time, r.name(), want,
               prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pops with occasional ignored items and rewrites of entries in the active lists.
  task automatic pop_stream(input int count, input int k, input int n);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 24) == 0)
        send_item(OP_ILLEGAL, 3'($urandom), 5'($urandom), $urandom);
      if ($urandom_range(0, 32) == 0)
        send_item(OP_LOAD, 3'($urandom_range(0, k - 1)), 5'($urandom_range(0, n - 1)),
                  $urandom);
      send_item(OP_POP, 3'($urandom), 5'($urandom), $urandom);
    end
  endtask

  // One merge run: configure, load every list in random order, start, pop them all.
  task automatic run_merge(input logic [LISTS_W-1:0] cfg_k, input logic [LENGTH_W-1:0] cfg_n,
                           input bit squeeze);
    int                        k, n, i, j, slot, tmp, cut;
    int                        vals [$];
    int                        order [$];
    logic signed [VALUE_W-1:0] plan [MAX_LISTS_DEF][MAX_LIST_LENGTH_DEF];
    bit                        narrow, sorted;
    write_reg(REG_LISTS, APB_DW'(cfg_k));
    write_reg(REG_LENGTH, APB_DW'(cfg_n));
    k = sb.active_lists();
    n = sb.active_length();
    calm   = ($urandom_range(0, 3) == 0);
    narrow = ($urandom_range(0, 3) == 0);
    sorted = ($urandom_range(0, 6) != 0);
    merge_runs++;

    // Narrow values give many ties between lists.
    for (i = 0; i < k; i++) begin
      vals.delete();
      for (j = 0; j < n; j++)
        vals.push_back(narrow ? int'($urandom_range(0, 6)) - 3 : int'($urandom));
      if (sorted) vals.sort();
      for (j = 0; j < n; j++) plan[i][j] = vals[j];
    end

    // Shuffle the load order across lists and positions.
    order.delete();
    for (i = 0; i < k; i++)
      for (j = 0; j < n; j++) order.push_back(i * MAX_LIST_LENGTH_DEF + j);
    for (i = order.size() - 1; i > 0; i--) begin
      slot = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[slot];
      order[slot] = tmp;
    end
    foreach (order[x]) begin
      i = order[x] / MAX_LIST_LENGTH_DEF;
      j = order[x] % MAX_LIST_LENGTH_DEF;
      if ($urandom_range(0, 12) == 0) send_item(OP_LOAD, 3'(i), 5'(j), $urandom);
      if ($urandom_range(0, 24) == 0)
        send_item(OP_ILLEGAL, 3'($urandom), 5'($urandom), $urandom);
      send_item(OP_LOAD, 3'(i), 5'(j), plan[i][j]);
    end

    send_item(OP_START, 3'($urandom), 5'($urandom), $urandom);
    if (squeeze) hold_req = 1'b1;

    // Sometimes the merge is abandoned partway and started over.
    if (k * n > 1 && $urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, k * n - 1);
      pop_stream(cut, k, n);
      send_item(OP_START, 3'($urandom), 5'($urandom), $urandom);
    end
    pop_stream(k * n + $urandom_range(0, 2), k, n);
  endtask

  // Result side: random stalls, calm stretches, and one long hold on request.
  initial begin : result_sink
    int left;
    bit stalling;
    left        = 0;
    stalling    = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        left = 0;
        out_stall_i <= 1'b0;
      end else begin
        if (left == 0) begin
          stalling = !calm && ($urandom_range(0, 99) < 35);
          if (stalling)
            left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
          else
            left = $urandom_range(1, 25);
        end
        out_stall_i <= stalling;
        left--;
      end
    end
  end

  // Check every result the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(merged_value_o, last_flag_o, status_o);
  end

  // Watchdog: end the run if no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still outstanding", $time,
               sb.pending.size());
      $display("FAIL");
      $finish;
    end
  end

  // Main sequence: reset, directed corner cases, then random merge runs.
  initial begin : stimulus
    int                  i, phase;
    logic [LISTS_W-1:0]  cfg_k;
    logic [LENGTH_W-1:0] cfg_n;
    sb              = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operation_i     = OP_LOAD;
    list_number_i   = '0;
    position_i      = '0;
    element_value_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    merge_runs      = 0;
    idle_cycles     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A pop before any start finds nothing; the unused operation is ignored.
    send_item(OP_POP, 3'd0, 5'd0, '0);
    send_item(OP_ILLEGAL, 3'd7, 5'd31, 32'hFFFF_FFFF);

    // Zero register values saturate to a single list of one element.
    write_reg(REG_LISTS, APB_DW'(0));
    write_reg(REG_LENGTH, APB_DW'(0));
    send_item(OP_LOAD, 3'd0, 5'd0, 32'h7FFF_FFFF);
    send_item(OP_START, 3'd0, 5'd0, '0);
    send_item(OP_POP, 3'd0, 5'd0, '0);
    send_item(OP_POP, 3'd0, 5'd0, '0);

    // An oversized list count saturates to eight lists of corner values, ties included.
    write_reg(REG_LISTS, APB_DW'(15));
    write_reg(REG_LENGTH, APB_DW'(1));
    for (i = 0; i < MAX_LISTS_DEF; i++) send_item(OP_LOAD, 3'(i), 5'd0, CORNER[i]);
    send_item(OP_START, 3'd0, 5'd0, '0);
    for (i = 0; i <= MAX_LISTS_DEF; i++) send_item(OP_POP, 3'd0, 5'd0, '0);

    // A longer list length after the merge leaves a spent root: still nothing to pop.
    write_reg(REG_LENGTH, APB_DW'(2));
    send_item(OP_POP, 3'd0, 5'd0, '0);

    // Random merge runs, mostly small; one full-size run under a long hold, one single long list.
    phase = 0;
    while (sb.items < ITEM_GOAL) begin
      if (phase == 1) begin
        run_merge(4'd15, 6'd63, 1'b1);
      end else if (phase == 3) begin
        run_merge(4'd1, 6'd32, 1'b0);
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          cfg_k = 4'($urandom_range(1, 2));
          cfg_n = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
        end else if ($urandom_range(0, 5) == 0) begin
          cfg_k = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
          cfg_n = 6'($urandom_range(1, 6));
        end else begin
          cfg_k = 4'($urandom_range(1, 8));
          cfg_n = 6'($urandom_range(1, 6));
        end
        run_merge(cfg_k, cfg_n, 1'b0);
      end
      phase++;
    end

    wait_idle();
    $display("Merged %0d runs from %0d items; %0d results checked, %0d of them empty.",
             merge_runs, sb.items, sb.results, sb.empties);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/kwm_pkg.sv
sv/kwm_cell.sv
sv/k_way_merge_min_heap_top.sv
test/k_way_merge_min_heap_top_tb.sv
